// ----- sv/mer_pkg.sv -----
package mer_pkg;

  localparam int NUM_CHANNELS_DEF = 4;
  localparam int COUNT_BITS_DEF   = 16;

  localparam int CH_W   = 2;
  localparam int REQ_W  = 3;
  localparam int THR_W  = 16;
  localparam int LIM_W  = 8;
  localparam int CFG_IDX_W = 1;
  localparam int IN_W   = 8;
  localparam int OUT_W  = 32;

  localparam logic [THR_W-1:0] THR_RST = 16'd1;
  localparam logic [LIM_W-1:0] LIM_RST = 8'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 1'b0,
    CFG_EMPTY_LIM = 1'b1
  } cfg_idx_e;

  typedef enum logic [REQ_W-1:0] {
    REQ_EVENT  = 3'd0,
    REQ_TICK   = 3'd1,
    REQ_MASK   = 3'd2,
    REQ_UNMASK = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_e;

  // control broadcast to every cell of the counter chain
  typedef struct packed {
    logic            inc_req;
    logic            mask_set;
    logic            mask_clr;
    logic            shift;
    logic [CH_W-1:0] chan;
  } cell_ctl_t;

endpackage

// ----- sv/multichannel_event_rate_alarm.sv -----
// channel   dir  handshake               payload
// s_axis    in   tvalid/tready           tdata: req_type[2:0], channel[4:3]
// m_axis    out  tvalid/tready, tlast    tdata: see port comment; tlast = last
// cfg       in   cfg_we_i (no wait)      cfg_idx_i selects register, cfg_data_i
//
// Event, mask and unmask words are applied in the cells as they are accepted.
// A window tick holds the input off through ST_SCAN, which rotates the counts once
// round the cell chain for the totals, and ST_EMIT, which sends one result word per
// shift as the chain shifts the counts out and zeroes fill in behind.
// A clear-alarm word passes through ST_CLEAR, which waits for the output register.
// Output back-pressure stalls the result words and the input with them; reset clears
// the control state and the counts at once, the output data has no reset.
module multichannel_event_rate_alarm #(
  parameter int NUM_CHANNELS = mer_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_BITS   = mer_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [2:0] req_type, [4:3] channel, [7:5] zero
  input  logic [mer_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [1:0] chan_index, [17:2] event_count, [18] over_limit, [21:19] over_channels,
  // [22] alarm, [30:23] empty_ticks, [31] expired
  output logic [mer_pkg::OUT_W-1:0]     m_axis_tdata,
  output logic                          m_axis_tlast,
  input  logic                          cfg_we_i,
  input  logic [mer_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mer_pkg::THR_W-1:0]     cfg_data_i
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int OT_W  = $clog2(NUM_CHANNELS + 1);
  localparam int EXT_W = COUNT_BITS + 16;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_EMIT  = 4'b0100,
    ST_CLEAR = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [mer_pkg::THR_W-1:0] thr_q;
  logic [mer_pkg::LIM_W-1:0] lim_q;

  logic [IDX_W-1:0] step_q, step_d;
  logic [OT_W-1:0]  over_q, over_d;
  logic             any_q, any_d;
  logic             alarm_q, alarm_d;
  logic [7:0]       run_q, run_d;
  logic             exp_q, exp_d;

  logic                  out_valid_q, out_valid_d;
  logic [1:0]            out_chan_q, out_chan_d;
  logic [15:0]           out_count_q, out_count_d;
  logic                  out_over_q, out_over_d;
  logic [2:0]            out_ot_q, out_ot_d;
  logic                  out_alarm_q, out_alarm_d;
  logic [7:0]            out_run_q, out_run_d;
  logic                  out_exp_q, out_exp_d;
  logic                  out_last_q, out_last_d;

  logic [mer_pkg::REQ_W-1:0] in_req;
  logic [mer_pkg::CH_W-1:0]  in_chan;
  logic                      in_fire, out_free, last_step, emit_shift;
  logic [COUNT_BITS-1:0]     count [NUM_CHANNELS];
  logic [COUNT_BITS-1:0]     nb    [NUM_CHANNELS];
  logic [EXT_W-1:0]          head_ext;
  logic                      head_over, head_nz;
  logic [IDX_W+1:0]          step_ext;
  logic [OT_W:0]             over_dbl;
  logic                      any_count;
  mer_pkg::cell_ctl_t        ctl;

  assign in_req   = s_axis_tdata[2:0];
  assign in_chan  = s_axis_tdata[4:3];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign last_step = (step_q == IDX_W'(NUM_CHANNELS - 1));
  assign emit_shift = (state_q == ST_EMIT) && out_free;

  assign head_ext  = EXT_W'(count[0]);
  assign head_nz   = (count[0] != '0);
  assign head_over = head_nz && (head_ext >= EXT_W'(thr_q));
  assign step_ext  = (IDX_W + 2)'(step_q);

  always_comb begin
    ctl          = '0;
    ctl.chan     = in_chan;
    ctl.inc_req  = in_fire && (in_req == mer_pkg::REQ_EVENT);
    ctl.mask_set = in_fire && (in_req == mer_pkg::REQ_MASK);
    ctl.mask_clr = in_fire && (in_req == mer_pkg::REQ_UNMASK);
    ctl.shift    = (state_q == ST_SCAN) || emit_shift;
  end

  // ring during the scan; zeroes enter at the tail while results leave
  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
    if (i == NUM_CHANNELS - 1) begin : g_tail
      assign nb[i] = emit_shift ? '0 : count[0];
    end else begin : g_mid
      assign nb[i] = count[i+1];
    end
    mer_cell #(
      .COUNT_BITS (COUNT_BITS),
      .INDEX      (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .nb_count_i (nb[i]),
      .count_o    (count[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    over_d      = over_q;
    any_d       = any_q;
    alarm_d     = alarm_q;
    run_d       = run_q;
    exp_d       = exp_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_chan_d  = out_chan_q;
    out_count_d = out_count_q;
    out_over_d  = out_over_q;
    out_ot_d    = out_ot_q;
    out_alarm_d = out_alarm_q;
    out_run_d   = out_run_q;
    out_exp_d   = out_exp_q;
    out_last_d  = out_last_q;
    over_dbl    = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_req == mer_pkg::REQ_TICK)) begin
          step_d  = '0;
          over_d  = '0;
          any_d   = 1'b0;
          state_d = ST_SCAN;
        end else if (in_fire && (in_req == mer_pkg::REQ_CLEAR)) begin
          over_dbl = {over_q, 1'b0};
          alarm_d  = (over_dbl >= (OT_W + 1)'(NUM_CHANNELS));
          state_d  = ST_CLEAR;
        end
      end
      ST_SCAN: begin
        over_d = over_q + OT_W'(head_over);
        any_d  = any_q || head_nz;
        step_d = step_q + IDX_W'(1);
        if (last_step) begin
          step_d   = '0;
          over_dbl = {over_d, 1'b0};
          if (over_dbl >= (OT_W + 1)'(NUM_CHANNELS)) begin
            alarm_d = 1'b1;
          end
          exp_d = 1'b0;
          if (any_d) begin
            run_d = '0;
          end else if (run_q != 8'hFF) begin
            run_d = run_q + 8'd1;
            exp_d = (run_d == lim_q);
          end
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_chan_d  = step_ext[1:0];
          out_count_d = (head_ext > EXT_W'(16'hFFFF)) ? 16'hFFFF : head_ext[15:0];
          out_over_d  = head_over;
          out_ot_d    = 3'(over_q);
          out_alarm_d = alarm_q;
          out_run_d   = run_q;
          out_exp_d   = exp_q;
          out_last_d  = last_step;
          step_d      = step_q + IDX_W'(1);
          if (last_step) begin
            step_d  = '0;
            state_d = ST_IDLE;
          end
        end
      end
      ST_CLEAR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_chan_d  = '0;
          out_count_d = '0;
          out_over_d  = 1'b0;
          out_ot_d    = 3'(over_q);
          out_alarm_d = alarm_q;
          out_run_d   = run_q;
          out_exp_d   = 1'b0;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      over_q      <= '0;
      any_q       <= 1'b0;
      alarm_q     <= 1'b0;
      run_q       <= '0;
      exp_q       <= 1'b0;
      out_valid_q <= 1'b0;
      thr_q       <= mer_pkg::THR_RST;
      lim_q       <= mer_pkg::LIM_RST;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      over_q      <= over_d;
      any_q       <= any_d;
      alarm_q     <= alarm_d;
      run_q       <= run_d;
      exp_q       <= exp_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_idx_i == mer_pkg::CFG_THRESHOLD)) begin
        thr_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_idx_i == mer_pkg::CFG_EMPTY_LIM)) begin
        lim_q <= cfg_data_i[mer_pkg::LIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_chan_q  <= out_chan_d;
    out_count_q <= out_count_d;
    out_over_q  <= out_over_d;
    out_ot_q    <= out_ot_d;
    out_alarm_q <= out_alarm_d;
    out_run_q   <= out_run_d;
    out_exp_q   <= out_exp_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {out_exp_q, out_run_q, out_alarm_q, out_ot_q,
                          out_over_q, out_count_q, out_chan_q};

  always_comb begin
    any_count = 1'b0;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      any_count = any_count || (count[k] != '0);
    end
  end

  // window counts are all zero once the final result word has been loaded
  a_counts_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free && last_step) |=> !any_count)
    else $error("counts not cleared after tick");

  a_over_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    over_q <= OT_W'(NUM_CHANNELS))
    else $error("over total exceeds channel count");

  // the alarm only drops through a clear request
  a_alarm_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(alarm_q) |-> $past(in_fire && (in_req == mer_pkg::REQ_CLEAR)))
    else $error("alarm dropped without clear");

  a_expired_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_exp_q) |-> (out_run_q == lim_q))
    else $error("expired flagged off the limit");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |=> (state_q == ST_SCAN || state_q == ST_EMIT))
    else $error("scan left early");

endmodule

// ----- sv/mer_cell.sv -----
module mer_cell #(
  parameter int COUNT_BITS = mer_pkg::COUNT_BITS_DEF,
  parameter int INDEX      = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mer_pkg::cell_ctl_t    ctl_i,
  input  logic [COUNT_BITS-1:0] nb_count_i,
  output logic [COUNT_BITS-1:0] count_o
);

  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  mask_q, mask_d;
  logic                  hit;

  assign hit = (int'(ctl_i.chan) == INDEX);

  always_comb begin
    count_d = count_q;
    mask_d  = mask_q;
    if (ctl_i.shift) begin
      count_d = nb_count_i;
    end else if (ctl_i.inc_req && hit && !mask_q && (count_q != '1)) begin
      count_d = count_q + COUNT_BITS'(1);
    end
    if (hit && ctl_i.mask_set) begin
      mask_d = 1'b1;
    end else if (hit && ctl_i.mask_clr) begin
      mask_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      mask_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      mask_q  <= mask_d;
    end
  end

  assign count_o = count_q;

endmodule
